// ===== sv/hpw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared types and operation codes for the heap-order postorder walker: the
// child probes that the store returns and the result request that the
// sequencer issues.
// ----------------------------------------------------------------------------
package hpw_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WALK = 1'b1;

  typedef struct packed {
    logic root;
    logic left;
    logic right;
    logic sibling;
  } probe_t;

  typedef struct packed {
    logic fire;
    logic last;
    logic empty;
  } emit_t;

endpackage
`default_nettype wire

// ===== sv/heap_tree_postorder_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heap_tree_postorder_walker
// Loads a heap-order binary tree slot by slot and walks it in postorder,
// one item per present node reachable from the root, or one tree_empty item.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   op, slot_index, slot_present,
//                                             slot_value
//   res      out        res_valid/res_stall   node_value, is_last, tree_empty
//
// A walk moves down through the descent state and, after each move up to a
// parent, passes a wait state that covers the registered value-memory read.
// Reset clears the present bits; values are undefined until loaded.
// req_stall stays high for the whole walk; a stalled result holds in the
// output register while the walk waits.
// ----------------------------------------------------------------------------
module heap_tree_postorder_walker
  import hpw_pkg::*;
#(
  parameter int NODES = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        op,
  input  wire logic [3:0]  slot_index,
  input  wire logic        slot_present,
  input  wire logic [15:0] slot_value,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [15:0]      node_value,
  output logic             is_last,
  output logic             tree_empty
);

  localparam int IW = $clog2(NODES + 1);

  logic          accept;
  logic          slot_ok;
  logic          wr_en;
  logic          start;
  logic          busy;
  logic          out_free;
  logic [IW-1:0] cur;
  logic [15:0]   rd_value;
  probe_t        probe;
  emit_t         emit;

  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign slot_ok   = (slot_index != 4'd0) && (32'(slot_index) <= 32'(NODES));
  assign wr_en     = accept && (op != OP_WALK) && slot_ok;
  assign start     = accept && (op == OP_WALK);
  assign out_free  = !res_valid || !res_stall;

  hpw_store #(.NODES(NODES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_idx     (IW'(slot_index)),
    .wr_present (slot_present),
    .wr_value   (slot_value),
    .cur        (cur),
    .probe      (probe),
    .rd_value   (rd_value)
  );

  hpw_walk #(.NODES(NODES)) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .probe    (probe),
    .cur      (cur),
    .busy     (busy),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit.fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.fire) begin
      node_value <= emit.empty ? 16'd0 : rd_value;
      is_last    <= emit.last;
      tree_empty <= emit.empty;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hpw_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpw_store
// Node storage: present bits in flip-flops cleared by reset, node values in
// a synchronous memory read at the current slot. Present lookups for the
// current slot's children and right sibling go back to the sequencer.
// ----------------------------------------------------------------------------
module hpw_store
  import hpw_pkg::*;
#(
  parameter int NODES = 15,
  localparam int IW = $clog2(NODES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic          wr_present,
  input  wire logic [15:0]   wr_value,
  input  wire logic [IW-1:0] cur,
  output probe_t             probe,
  output logic [15:0]        rd_value
);

  logic [NODES:0] present;
  logic [15:0]    values [NODES+1];
  logic [IW:0]    left_idx;
  logic [IW:0]    right_idx;
  logic [IW:0]    sib_idx;
  logic [IW:0]    limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (wr_en) begin
      present[wr_idx] <= wr_present;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      values[wr_idx] <= wr_value;
    end
    rd_value <= values[cur];
  end

  always_comb begin
    limit         = (IW+1)'(NODES);
    left_idx      = {cur, 1'b0};
    right_idx     = {cur, 1'b1};
    sib_idx       = {1'b0, cur} + (IW+1)'(1);
    probe.root    = present[IW'(1)];
    probe.left    = (left_idx <= limit) && present[left_idx[IW-1:0]];
    probe.right   = (right_idx <= limit) && present[right_idx[IW-1:0]];
    probe.sibling = (sib_idx <= limit) && present[sib_idx[IW-1:0]];
  end

endmodule
`default_nettype wire

// ===== sv/hpw_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpw_walk
// Postorder sequencer. Descends to the first postorder node of a subtree,
// emits it, then moves to the right sibling's subtree or up to the parent,
// using heap-order index arithmetic in place of an explicit stack.
// ----------------------------------------------------------------------------
module hpw_walk
  import hpw_pkg::*;
#(
  parameter int NODES = 15,
  localparam int IW = $clog2(NODES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          out_free,
  input  wire probe_t        probe,
  output logic [IW-1:0]      cur,
  output logic               busy,
  output emit_t              emit
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DESC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [IW-1:0] cur_next;
  logic          empty;
  logic          empty_next;
  logic          at_root;

  assign at_root = (cur == IW'(1));
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cur_next   = cur;
    empty_next = empty;
    emit.fire  = 1'b0;
    emit.last  = empty || at_root;
    emit.empty = empty;
    case (state)
      S_IDLE: begin
        if (start) begin
          cur_next = IW'(1);
          if (probe.root) begin
            state_next = S_DESC;
          end else begin
            empty_next = 1'b1;
            state_next = S_EMIT;
          end
        end
      end
      S_DESC: begin
        if (probe.left) begin
          cur_next = IW'({cur, 1'b0});
        end else if (probe.right) begin
          cur_next = IW'({cur, 1'b1});
        end else begin
          state_next = S_EMIT;
        end
      end
      S_WAIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit.fire = 1'b1;
          if (empty || at_root) begin
            empty_next = 1'b0;
            state_next = S_IDLE;
          end else if (!cur[0] && probe.sibling) begin
            cur_next   = cur | IW'(1);
            state_next = S_DESC;
          end else begin
            cur_next   = cur >> 1;
            state_next = S_WAIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b0;
      cur   <= IW'(1);
    end else begin
      state <= state_next;
      empty <= empty_next;
      cur   <= cur_next;
    end
  end

endmodule
`default_nettype wire
